FILE: hw/rtl/tun_pkg.sv
// Package: shared constants for the triangle unit normal block.
package tun_pkg;

  localparam int unsigned COORD_WIDTH  = 16;
  localparam int unsigned NORMAL_WIDTH = 16;
  localparam int unsigned NUM_AXES     = 3;

endpackage

FILE: hw/rtl/tun_if.sv
// Interfaces: triangle input channel and unit normal output channel.
interface tun_in_if #(
  parameter int unsigned CoordWidth = tun_pkg::COORD_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] first_x;
  logic signed [CoordWidth-1:0] first_y;
  logic signed [CoordWidth-1:0] first_z;
  logic signed [CoordWidth-1:0] second_x;
  logic signed [CoordWidth-1:0] second_y;
  logic signed [CoordWidth-1:0] second_z;
  logic signed [CoordWidth-1:0] third_x;
  logic signed [CoordWidth-1:0] third_y;
  logic signed [CoordWidth-1:0] third_z;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
           third_x, third_y, third_z,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
           third_x, third_y, third_z,
    output ready
  );
endinterface

interface tun_out_if #(
  parameter int unsigned NormalWidth = tun_pkg::NORMAL_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [NormalWidth-1:0] normal_x;
  logic signed [NormalWidth-1:0] normal_y;
  logic signed [NormalWidth-1:0] normal_z;
  logic                          degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, degenerate,
    output ready
  );
endinterface

FILE: hw/rtl/tun_cross.sv
// Edge vectors, partial products and cross product (two stages).
module tun_cross #(
  parameter int unsigned CoordWidth = tun_pkg::COORD_WIDTH
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic signed [CoordWidth-1:0]            first_x_i,
  input  logic signed [CoordWidth-1:0]            first_y_i,
  input  logic signed [CoordWidth-1:0]            first_z_i,
  input  logic signed [CoordWidth-1:0]            second_x_i,
  input  logic signed [CoordWidth-1:0]            second_y_i,
  input  logic signed [CoordWidth-1:0]            second_z_i,
  input  logic signed [CoordWidth-1:0]            third_x_i,
  input  logic signed [CoordWidth-1:0]            third_y_i,
  input  logic signed [CoordWidth-1:0]            third_z_i,
  output logic                                    valid_o,
  output logic [tun_pkg::NUM_AXES-1:0]            neg_o,
  output logic [tun_pkg::NUM_AXES-1:0][2*CoordWidth+2:0] mag_o
);
  localparam int unsigned EW = CoordWidth + 1;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned XW = PW + 1;

  logic signed [EW-1:0] ax, ay, az, bx, by, bz;
  logic [5:0][PW-1:0]   prod_d, prod_q;
  logic                 vld1_q, vld2_q;
  logic [tun_pkg::NUM_AXES-1:0][XW-1:0] mag_d, mag_q;
  logic [tun_pkg::NUM_AXES-1:0]         neg_d, neg_q;
  logic signed [XW-1:0] cr [tun_pkg::NUM_AXES];

  always_comb begin
    ax = EW'(first_x_i) - EW'(second_x_i);
    ay = EW'(first_y_i) - EW'(second_y_i);
    az = EW'(first_z_i) - EW'(second_z_i);
    bx = EW'(second_x_i) - EW'(third_x_i);
    by = EW'(second_y_i) - EW'(third_y_i);
    bz = EW'(second_z_i) - EW'(third_z_i);
    prod_d[0] = PW'(ay * bz);
    prod_d[1] = PW'(az * by);
    prod_d[2] = PW'(az * bx);
    prod_d[3] = PW'(ax * bz);
    prod_d[4] = PW'(ax * by);
    prod_d[5] = PW'(ay * bx);
  end

  always_comb begin
    for (int k = 0; k < tun_pkg::NUM_AXES; k++) begin
      cr[k]    = XW'($signed(prod_q[2*k])) - XW'($signed(prod_q[2*k+1]));
      neg_d[k] = cr[k][XW-1];
      mag_d[k] = neg_d[k] ? XW'(-cr[k]) : XW'(cr[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      mag_q  <= mag_d;
      neg_q  <= neg_d;
    end
  end

  assign valid_o = vld2_q;
  assign neg_o   = neg_q;
  assign mag_o   = mag_q;
endmodule

FILE: hw/rtl/tun_square.sv
// Squared components, squared length and root search seed (two stages).
module tun_square #(
  parameter int unsigned CoordWidth  = tun_pkg::COORD_WIDTH,
  parameter int unsigned NormalWidth = tun_pkg::NORMAL_WIDTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic [tun_pkg::NUM_AXES-1:0] neg_i,
  input  logic [tun_pkg::NUM_AXES-1:0][2*CoordWidth+2:0] mag_i,
  output logic valid_o,
  output logic degen_o,
  output logic [tun_pkg::NUM_AXES-1:0] neg_o,
  output logic [4*CoordWidth+7:0] s_o,
  output logic [tun_pkg::NUM_AXES-1:0][4*CoordWidth+2*NormalWidth+11:0] r_o,
  output logic [tun_pkg::NUM_AXES-1:0][4*CoordWidth+2*NormalWidth+11:0] p_o
);
  localparam int unsigned XW = 2 * CoordWidth + 3;
  localparam int unsigned SQ = 2 * XW;
  localparam int unsigned SW = SQ + 2;
  localparam int unsigned DW = SW + 2 * NormalWidth + 4;

  logic [tun_pkg::NUM_AXES-1:0][SQ-1:0] sq_q;
  logic [tun_pkg::NUM_AXES-1:0]         neg1_q, neg2_q;
  logic                                 vld1_q, vld2_q;
  logic [SW-1:0]                        s_d, s_q;
  logic [tun_pkg::NUM_AXES-1:0][DW-1:0] r_d, r_q, p_d, p_q;
  logic                                 degen_q;

  always_comb begin
    s_d = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
    for (int k = 0; k < tun_pkg::NUM_AXES; k++) begin
      // R = T - S with T = c^2 * 2^(2*NW); P = (2q-1)*S at q = 0
      r_d[k] = (DW'(sq_q[k]) << (2 * NormalWidth)) - DW'(s_d);
      p_d[k] = DW'(0) - DW'(s_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < tun_pkg::NUM_AXES; k++) begin
        sq_q[k] <= SQ'(mag_i[k] * mag_i[k]);
      end
      neg1_q  <= neg_i;
      neg2_q  <= neg1_q;
      s_q     <= s_d;
      r_q     <= r_d;
      p_q     <= p_d;
      degen_q <= (s_d == '0);
    end
  end

  assign valid_o = vld2_q;
  assign degen_o = degen_q;
  assign neg_o   = neg2_q;
  assign s_o     = s_q;
  assign r_o     = r_q;
  assign p_o     = p_q;
endmodule

FILE: hw/rtl/tun_root_step.sv
// One bit of the rounded quotient c*2^(NW-1)/sqrt(S) for all three axes.
module tun_root_step #(
  parameter int unsigned CoordWidth  = tun_pkg::COORD_WIDTH,
  parameter int unsigned NormalWidth = tun_pkg::NORMAL_WIDTH,
  parameter int unsigned Bit         = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic degen_i,
  input  logic [tun_pkg::NUM_AXES-1:0] neg_i,
  input  logic [4*CoordWidth+7:0] s_i,
  input  logic [tun_pkg::NUM_AXES-1:0][4*CoordWidth+2*NormalWidth+11:0] r_i,
  input  logic [tun_pkg::NUM_AXES-1:0][4*CoordWidth+2*NormalWidth+11:0] p_i,
  input  logic [tun_pkg::NUM_AXES-1:0][NormalWidth-1:0] q_i,
  output logic valid_o,
  output logic degen_o,
  output logic [tun_pkg::NUM_AXES-1:0] neg_o,
  output logic [4*CoordWidth+7:0] s_o,
  output logic [tun_pkg::NUM_AXES-1:0][4*CoordWidth+2*NormalWidth+11:0] r_o,
  output logic [tun_pkg::NUM_AXES-1:0][4*CoordWidth+2*NormalWidth+11:0] p_o,
  output logic [tun_pkg::NUM_AXES-1:0][NormalWidth-1:0] q_o
);
  localparam int unsigned SW = 4 * CoordWidth + 8;
  localparam int unsigned DW = SW + 2 * NormalWidth + 4;

  logic signed [DW-1:0] d    [tun_pkg::NUM_AXES];
  logic [tun_pkg::NUM_AXES-1:0][DW-1:0]          r_d, r_q, p_d, p_q;
  logic [tun_pkg::NUM_AXES-1:0][NormalWidth-1:0] q_d, q_q;
  logic [SW-1:0]                                 s_q;
  logic [tun_pkg::NUM_AXES-1:0]                  neg_q;
  logic                                          vld_q, degen_q;

  // (2q+2^(b+1)-1)^2*S = (2q-1)^2*S + 2^(b+2)*P + 2^(2b+2)*S
  always_comb begin
    for (int k = 0; k < tun_pkg::NUM_AXES; k++) begin
      d[k] = ($signed(p_i[k]) <<< (Bit + 2)) + $signed(DW'(s_i) << (2 * Bit + 2));
      r_d[k] = r_i[k];
      p_d[k] = p_i[k];
      q_d[k] = q_i[k];
      if (d[k] <= $signed(r_i[k])) begin
        r_d[k] = DW'($signed(r_i[k]) - d[k]);
        p_d[k] = p_i[k] + (DW'(s_i) << (Bit + 1));
        q_d[k] = q_i[k] | (NormalWidth'(1) << Bit);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q     <= r_d;
      p_q     <= p_d;
      q_q     <= q_d;
      s_q     <= s_i;
      neg_q   <= neg_i;
      degen_q <= degen_i;
    end
  end

  assign valid_o = vld_q;
  assign degen_o = degen_q;
  assign neg_o   = neg_q;
  assign s_o     = s_q;
  assign r_o     = r_q;
  assign p_o     = p_q;
  assign q_o     = q_q;
endmodule

FILE: hw/rtl/triangle_unit_normal_top.sv
// Throughput: one triangle per cycle while the result is not stalled; the
// bit-per-stage root search over NORMAL_WIDTH stages sets the depth, and the
// whole pipeline advances together.
// A stalled result holds every stage; input ready = result slot free or taken.
// Reset clears all valid bits asynchronously; the data path is not reset.
module triangle_unit_normal_top #(
  parameter int unsigned CoordWidth  = tun_pkg::COORD_WIDTH,
  parameter int unsigned NormalWidth = tun_pkg::NORMAL_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tun_in_if.sink    in_i,
  tun_out_if.source out_o
);
  localparam int unsigned XW = 2 * CoordWidth + 3;
  localparam int unsigned SW = 4 * CoordWidth + 8;
  localparam int unsigned DW = SW + 2 * NormalWidth + 4;
  localparam logic [NormalWidth-1:0] Lim = {1'b0, {(NormalWidth-1){1'b1}}};

  logic en;
  logic cr_valid;
  logic [tun_pkg::NUM_AXES-1:0]         cr_neg;
  logic [tun_pkg::NUM_AXES-1:0][XW-1:0] cr_mag;

  logic [NormalWidth:0]                                   st_valid, st_degen;
  logic [NormalWidth:0][tun_pkg::NUM_AXES-1:0]            st_neg;
  logic [NormalWidth:0][SW-1:0]                           st_s;
  logic [NormalWidth:0][tun_pkg::NUM_AXES-1:0][DW-1:0]    st_r, st_p;
  logic [NormalWidth:0][tun_pkg::NUM_AXES-1:0][NormalWidth-1:0] st_q;

  logic                                          out_vld_q, out_deg_q;
  logic [tun_pkg::NUM_AXES-1:0][NormalWidth-1:0] nrm_d, nrm_q;
  logic [NormalWidth-1:0]                        qs;

  assign en       = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  tun_cross #(.CoordWidth(CoordWidth)) u_cross (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid),
    .first_x_i(in_i.first_x), .first_y_i(in_i.first_y), .first_z_i(in_i.first_z),
    .second_x_i(in_i.second_x), .second_y_i(in_i.second_y),
    .second_z_i(in_i.second_z),
    .third_x_i(in_i.third_x), .third_y_i(in_i.third_y), .third_z_i(in_i.third_z),
    .valid_o(cr_valid), .neg_o(cr_neg), .mag_o(cr_mag)
  );

  tun_square #(.CoordWidth(CoordWidth), .NormalWidth(NormalWidth)) u_square (
    .clk_i, .rst_ni, .en_i(en), .valid_i(cr_valid), .neg_i(cr_neg), .mag_i(cr_mag),
    .valid_o(st_valid[0]), .degen_o(st_degen[0]), .neg_o(st_neg[0]),
    .s_o(st_s[0]), .r_o(st_r[0]), .p_o(st_p[0])
  );
  assign st_q[0] = '0;

  for (genvar g = 0; g < NormalWidth; g++) begin : g_step
    tun_root_step #(
      .CoordWidth(CoordWidth), .NormalWidth(NormalWidth), .Bit(NormalWidth - 1 - g)
    ) u_step (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(st_valid[g]), .degen_i(st_degen[g]), .neg_i(st_neg[g]),
      .s_i(st_s[g]), .r_i(st_r[g]), .p_i(st_p[g]), .q_i(st_q[g]),
      .valid_o(st_valid[g+1]), .degen_o(st_degen[g+1]), .neg_o(st_neg[g+1]),
      .s_o(st_s[g+1]), .r_o(st_r[g+1]), .p_o(st_p[g+1]), .q_o(st_q[g+1])
    );
  end

  // saturate, restore sign, zero when degenerate
  always_comb begin
    qs = '0;
    for (int k = 0; k < tun_pkg::NUM_AXES; k++) begin
      qs = (st_q[NormalWidth][k] > Lim) ? Lim : st_q[NormalWidth][k];
      if (st_degen[NormalWidth]) begin
        nrm_d[k] = '0;
      end else begin
        nrm_d[k] = st_neg[NormalWidth][k] ? NormalWidth'(-qs) : qs;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= st_valid[NormalWidth];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nrm_q     <= nrm_d;
      out_deg_q <= st_degen[NormalWidth];
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.normal_x   = nrm_q[0];
  assign out_o.normal_y   = nrm_q[1];
  assign out_o.normal_z   = nrm_q[2];
  assign out_o.degenerate = out_deg_q;

  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.degenerate |->
      out_o.normal_x == '0 && out_o.normal_y == '0 && out_o.normal_z == '0)
    else $error("degenerate result with nonzero normal");

  a_no_min_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.normal_x != {1'b1, {(NormalWidth-1){1'b0}}} &&
      out_o.normal_y != {1'b1, {(NormalWidth-1){1'b0}}} &&
      out_o.normal_z != {1'b1, {(NormalWidth-1){1'b0}}})
    else $error("normal component outside saturation range");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(nrm_q))
    else $error("result changed while stalled");

  a_ready_rule : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == (!out_o.valid || out_o.ready))
    else $error("input ready does not follow result slot");
endmodule

FILE: sim/tb_top.sv
// Testbench for triangle_unit_normal_top: directed and random triangles vs. a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [tun_pkg::COORD_WIDTH-1:0]  coord_t;
  typedef logic signed [tun_pkg::NORMAL_WIDTH-1:0] comp_t;
  typedef coord_t tri_t [9];  // first xyz, second xyz, third xyz
  typedef struct {
    comp_t nx;
    comp_t ny;
    comp_t nz;
    logic  degen;
  } normal_t;

  logic clk_i;
  logic rst_ni;

  tun_in_if  in_if ();
  tun_out_if out_if ();

  triangle_unit_normal_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  normal_t normal_q[$];
  int      n_err;
  int      n_sent;
  int      n_checked;
  int      n_degen;
  int      n_sat;
  bit      tx_idle;
  bit      rx_idle;
  int      rx_hold;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("timeout with %0d results outstanding", normal_q.size());
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report(input string msg);
    n_err++;
    if (n_err <= 30) $display("%0t: %s", $realtime, msg);
  endtask

  // Exact unit normal: component = round(2^(NW-1) * c / sqrt(S)), found bit by bit.
  function automatic normal_t predict_normal(input tri_t t);
    longint      ax, ay, az, bx, by, bz;
    longint      cr [3];
    logic [127:0] mag [3];
    logic [127:0] s, m, sq, cand, k, q, lim;
    comp_t        comp [3];
    normal_t      r;
    ax = longint'(t[0]) - longint'(t[3]);
    ay = longint'(t[1]) - longint'(t[4]);
    az = longint'(t[2]) - longint'(t[5]);
    bx = longint'(t[3]) - longint'(t[6]);
    by = longint'(t[4]) - longint'(t[7]);
    bz = longint'(t[5]) - longint'(t[8]);
    cr[0] = ay * bz - az * by;
    cr[1] = az * bx - ax * bz;
    cr[2] = ax * by - ay * bx;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (cr[i] < 0) ? 128'(-cr[i]) : 128'(cr[i]);
      s += mag[i] * mag[i];
    end
    lim = (128'd1 << (tun_pkg::NORMAL_WIDTH - 1)) - 1;
    for (int i = 0; i < 3; i++) begin
      m  = mag[i] << tun_pkg::NORMAL_WIDTH;
      sq = m * m;
      q  = '0;
      for (int b = tun_pkg::NORMAL_WIDTH - 1; b >= 0; b--) begin
        cand = q | (128'd1 << b);
        k    = 2 * cand - 1;
        if (k * k * s <= sq) q = cand;
      end
      if (q > lim) q = lim;
      if (cr[i] < 0) q = -q;
      comp[i] = q[tun_pkg::NORMAL_WIDTH-1:0];
    end
    if (s == 0) begin
      r = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
    end else begin
      r = '{nx: comp[0], ny: comp[1], nz: comp[2], degen: 1'b0};
    end
    return r;
  endfunction

  // One transaction on the triangle channel; valid stays high across back-to-back items.
  task automatic send_triangle(input tri_t t);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.first_x  <= t[0];
    in_if.first_y  <= t[1];
    in_if.first_z  <= t[2];
    in_if.second_x <= t[3];
    in_if.second_y <= t[4];
    in_if.second_z <= t[5];
    in_if.third_x  <= t[6];
    in_if.third_y  <= t[7];
    in_if.third_z  <= t[8];
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    normal_q.push_back(predict_normal(t));
    n_sent++;
  endtask

  // Result side: random stalls, plus a long hold-off when requested.
  initial begin
    int      stall;
    normal_t exp_n;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 8) : 0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      n_checked++;
      if (normal_q.size() == 0) begin
        report("result transaction with nothing expected");
      end else begin
        exp_n = normal_q.pop_front();
        if (exp_n.degen) n_degen++;
        if (!exp_n.degen && (exp_n.nx == 32767 || exp_n.nx == -32767 ||
            exp_n.ny == 32767 || exp_n.ny == -32767 ||
            exp_n.nz == 32767 || exp_n.nz == -32767)) n_sat++;
        if (out_if.normal_x !== exp_n.nx)
          report($sformatf("normal_x got %0d exp %0d", out_if.normal_x, exp_n.nx));
        if (out_if.normal_y !== exp_n.ny)
          report($sformatf("normal_y got %0d exp %0d", out_if.normal_y, exp_n.ny));
        if (out_if.normal_z !== exp_n.nz)
          report($sformatf("normal_z got %0d exp %0d", out_if.normal_z, exp_n.nz));
        if (out_if.degenerate !== exp_n.degen)
          report($sformatf("degenerate got %b exp %b", out_if.degenerate, exp_n.degen));
      end
    end
  end

  function automatic coord_t rand_coord();
    int mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0: begin
        case ($urandom_range(0, 4))
          0: return -32768;
          1: return 32767;
          2: return -1;
          3: return 1;
          default: return 0;
        endcase
      end
      1, 2: return coord_t'($signed($urandom_range(0, 16)) - 8);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic tri_t rand_triangle();
    tri_t   t;
    coord_t dx, dy, dz;
    int     kind;
    kind = $urandom_range(0, 19);
    for (int i = 0; i < 9; i++) t[i] = rand_coord();
    if (kind == 0) begin
      // collinear: third continues the edge from first through second
      dx = coord_t'($signed($urandom_range(0, 200)) - 100);
      dy = coord_t'($signed($urandom_range(0, 200)) - 100);
      dz = coord_t'($signed($urandom_range(0, 200)) - 100);
      for (int i = 0; i < 3; i++) t[i] = coord_t'($signed($urandom_range(0, 2000)) - 1000);
      t[3] = t[0] + dx; t[4] = t[1] + dy; t[5] = t[2] + dz;
      t[6] = coord_t'(t[3] + 2 * dx);
      t[7] = coord_t'(t[4] + 2 * dy);
      t[8] = coord_t'(t[5] + 2 * dz);
    end else if (kind == 1) begin
      // repeated vertex
      for (int i = 0; i < 3; i++) t[3 + i] = t[6 + i];
    end
    return t;
  endfunction

  task automatic test_directed();
    tri_t t;
    t = '{default: 0};
    send_triangle(t);
    t = '{default: -32768};
    send_triangle(t);
    t = '{default: 32767};
    send_triangle(t);
    // unit right triangles in each plane: one component at full scale
    t = '{1, 0, 0, 0, 0, 0, 0, 1, 0};
    send_triangle(t);
    t = '{0, 1, 0, 0, 0, 0, 0, 0, 1};
    send_triangle(t);
    t = '{0, 0, 1, 0, 0, 0, 1, 0, 0};
    send_triangle(t);
    t = '{0, 1, 0, 0, 0, 0, 1, 0, 0};
    send_triangle(t);
    t = '{32767, 0, 0, -32768, 0, 0, -32768, 32767, 0};
    send_triangle(t);
    t = '{32767, 32767, 32767, -32768, -32768, -32768, 32767, -32768, 32767};
    send_triangle(t);
    t = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767};
    send_triangle(t);
    t = '{32767, -32768, 0, -32768, 32767, 0, 0, 0, -32768};
    send_triangle(t);
    // collinear and repeated vertices
    t = '{0, 0, 0, 1, 2, 3, 2, 4, 6};
    send_triangle(t);
    t = '{-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767};
    send_triangle(t);
    t = '{5, -7, 9, 5, -7, 9, 100, 3, -2};
    send_triangle(t);
    t = '{100, 3, -2, 5, -7, 9, 5, -7, 9};
    send_triangle(t);
    // equal magnitudes in two and three axes, and one axis alone
    t = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_triangle(t);
    t = '{1, 1, 0, 0, 0, 0, 1, -1, 0};
    send_triangle(t);
    t = '{-1, -1, -1, 0, 0, 0, 1, -1, 1};
    send_triangle(t);
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 9; j++) begin
        case ($urandom_range(0, 2))
          0: t[j] = -32768;
          1: t[j] = 32767;
          default: t[j] = 0;
        endcase
      end
      send_triangle(t);
    end
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      // occasional stretches with no idling on either side
      if (i % 150 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      send_triangle(rand_triangle());
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering: pipeline fills and stalls input.
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold = 300;
    for (int i = 0; i < 60; i++) send_triangle(rand_triangle());
    tx_idle = 1'b1;
  endtask

  // Sender pauses until every outstanding result is back.
  task automatic test_drain();
    for (int i = 0; i < 30; i++) send_triangle(rand_triangle());
    in_if.valid <= 1'b0;
    while (normal_q.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 30; i++) send_triangle(rand_triangle());
  endtask

  initial begin
    in_if.valid    = 1'b0;
    in_if.first_x  = '0;
    in_if.first_y  = '0;
    in_if.first_z  = '0;
    in_if.second_x = '0;
    in_if.second_y = '0;
    in_if.second_z = '0;
    in_if.third_x  = '0;
    in_if.third_y  = '0;
    in_if.third_z  = '0;
    tx_idle   = 1'b1;
    rx_idle   = 1'b1;
    rx_hold   = 0;
    n_err     = 0;
    n_sent    = 0;
    n_checked = 0;
    n_degen   = 0;
    n_sat     = 0;
    rst_ni    = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random(700);
    test_drain();
    test_random(40);

    in_if.valid <= 1'b0;
    while (normal_q.size() != 0) @(posedge clk_i);
    repeat (tun_pkg::NORMAL_WIDTH + 15) @(posedge clk_i);

    $display("triangles sent %0d, results checked %0d, degenerate %0d, full-scale %0d",
             n_sent, n_checked, n_degen, n_sat);
    $display("covered extremes, collinear and repeated vertices, long output stall, drain");
    if (n_err == 0 && normal_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("errors %0d, left over %0d", n_err, normal_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
